/* rtl/core/isms_pkg.sv */
// ----------------------------------------------------------------------------
// isms_pkg
// Shared types and constants of the Ising site update block.
// ----------------------------------------------------------------------------
package isms_pkg;

  localparam int unsigned COORD_W     = 7;
  localparam int unsigned COORD_RANGE = 2 ** COORD_W;
  localparam int unsigned ACT_W       = 2;
  localparam int unsigned DRAW_W      = 16;
  localparam int unsigned THR_W       = 16;
  localparam int unsigned DE_W        = 5;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned APB_AW      = 3;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TRIAL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  localparam logic [THR_W-1:0] THR_FOUR_RST  = 16'd1200;
  localparam logic [THR_W-1:0] THR_EIGHT_RST = 16'd22;

  localparam logic REG_THR_FOUR  = 1'b0;
  localparam logic REG_THR_EIGHT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd0;
    logic rd1;
    logic rd2;
    logic commit;
  } isms_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_write;
    logic out_free;
  } isms_sts_t;

endpackage

/* rtl/core/isms_if.sv */
// ----------------------------------------------------------------------------
// isms_in_if / isms_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface isms_in_if;
  logic                               valid;
  logic                               ready;
  logic [isms_pkg::ACT_W-1:0]         action;
  logic [isms_pkg::COORD_W-1:0]       row;
  logic [isms_pkg::COORD_W-1:0]       column;
  logic                               spin_value;
  logic [isms_pkg::DRAW_W-1:0]        random_draw;

  modport source (output valid, action, row, column, spin_value, random_draw, input ready);
  modport sink   (input valid, action, row, column, spin_value, random_draw, output ready);
endinterface

interface isms_out_if;
  logic                               valid;
  logic                               ready;
  logic                               spin_out;
  logic                               flipped;
  logic signed [isms_pkg::DE_W-1:0]   energy_change;

  modport source (output valid, spin_out, flipped, energy_change, input ready);
  modport sink   (input valid, spin_out, flipped, energy_change, output ready);
endinterface

/* rtl/core/isms_ctrl.sv */
// ----------------------------------------------------------------------------
// isms_ctrl
// Sequencer: accepts an item, steps the lattice reads, commits the result.
// ----------------------------------------------------------------------------
module isms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  isms_pkg::isms_sts_t sts,
  output isms_pkg::isms_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD0  = 5'b00010,
    ST_RD1  = 5'b00100,
    ST_RD2  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = ST_RD0;
      end
      ST_RD0: begin
        cmd.rd0   = 1'b1;
        state_nxt = sts.is_write ? ST_FIN : ST_RD1;
      end
      ST_RD1: begin
        cmd.rd1   = 1'b1;
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd2   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.commit = sts.out_free;
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* rtl/core/isms_dp.sv */
// ----------------------------------------------------------------------------
// isms_dp
// Lattice memory, neighbor capture, energy change, acceptance, result register.
// ----------------------------------------------------------------------------
module isms_dp #(
  parameter int unsigned LATTICE_SIDE = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  isms_pkg::isms_cmd_t                 cmd,
  output isms_pkg::isms_sts_t                 sts,
  input  logic [isms_pkg::ACT_W-1:0]          in_action,
  input  logic [isms_pkg::COORD_W-1:0]        in_row,
  input  logic [isms_pkg::COORD_W-1:0]        in_column,
  input  logic                                in_spin_value,
  input  logic [isms_pkg::DRAW_W-1:0]         in_random_draw,
  input  logic [isms_pkg::THR_W-1:0]          thr_four,
  input  logic [isms_pkg::THR_W-1:0]          thr_eight,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_spin_out,
  output logic                                out_flipped,
  output logic signed [isms_pkg::DE_W-1:0]    out_energy_change
);

  localparam int unsigned IDX_W  = $clog2(LATTICE_SIDE);
  localparam int unsigned SITES  = LATTICE_SIDE * LATTICE_SIDE;
  localparam int unsigned ADDR_W = $clog2(SITES);
  localparam int unsigned DE_W   = isms_pkg::DE_W;

  // coordinate reduction table
  logic [IDX_W-1:0] mod_tbl [isms_pkg::COORD_RANGE];
  for (genvar g = 0; g < isms_pkg::COORD_RANGE; g++) begin : g_mod
    localparam int unsigned MV = g % LATTICE_SIDE;
    assign mod_tbl[g] = IDX_W'(MV);
  end

  logic [isms_pkg::ACT_W-1:0]  act_r;
  logic [IDX_W-1:0]            row_r, col_r;
  logic                        wbit_r;
  logic [isms_pkg::DRAW_W-1:0] draw_r;
  logic                        rd0_d_r, rd1_d_r;
  logic                        ctr_r, nrp_r, nrm_r, ncp_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      row_r  <= mod_tbl[in_row];
      col_r  <= mod_tbl[in_column];
      wbit_r <= in_spin_value;
      draw_r <= in_random_draw;
    end
  end

  // wrapped neighbors
  logic [IDX_W-1:0] rp, rm, cp, cm;
  assign rp = (row_r == IDX_W'(LATTICE_SIDE - 1)) ? '0 : row_r + IDX_W'(1);
  assign rm = (row_r == '0) ? IDX_W'(LATTICE_SIDE - 1) : row_r - IDX_W'(1);
  assign cp = (col_r == IDX_W'(LATTICE_SIDE - 1)) ? '0 : col_r + IDX_W'(1);
  assign cm = (col_r == '0) ? IDX_W'(LATTICE_SIDE - 1) : col_r - IDX_W'(1);

  logic [IDX_W-1:0] ra_row, ra_col, rb_row, rb_col;
  always_comb begin
    ra_row = row_r;
    ra_col = col_r;
    rb_row = rp;
    rb_col = col_r;
    if (cmd.rd1) begin
      ra_row = rm;
      rb_row = row_r;
      rb_col = cp;
    end else if (cmd.rd2) begin
      ra_col = cm;
    end
  end

  logic [ADDR_W-1:0] addr_a, addr_b, addr_c;
  assign addr_a = ADDR_W'(ra_row) * ADDR_W'(LATTICE_SIDE) + ADDR_W'(ra_col);
  assign addr_b = ADDR_W'(rb_row) * ADDR_W'(LATTICE_SIDE) + ADDR_W'(rb_col);
  assign addr_c = ADDR_W'(row_r)  * ADDR_W'(LATTICE_SIDE) + ADDR_W'(col_r);

  // lattice memory: one write port, two registered read ports
  logic mem [SITES];
  logic qa_r, qb_r;
  logic rd_en;
  logic we;
  logic wd;

  assign rd_en = cmd.rd0 | cmd.rd1 | cmd.rd2;

  always_ff @(posedge clk) begin
    if (we)    mem[addr_c] <= wd;
    if (rd_en) begin
      qa_r <= mem[addr_a];
      qb_r <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd0_d_r <= 1'b0;
      rd1_d_r <= 1'b0;
    end else begin
      rd0_d_r <= cmd.rd0;
      rd1_d_r <= cmd.rd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd0_d_r) begin
      ctr_r <= qa_r;
      nrp_r <= qb_r;
    end
    if (rd1_d_r) begin
      nrm_r <= qa_r;
      ncp_r <= qb_r;
    end
  end

  // energy change: count of up neighbors k gives 4k-8 for an up center
  logic [2:0]             up_cnt;
  logic [DE_W-1:0]        de_up;
  logic signed [DE_W-1:0] de;
  logic                   is_trial, is_write, accept;

  assign up_cnt = 3'(nrp_r) + 3'(nrm_r) + 3'(ncp_r) + 3'(qa_r);
  assign de_up  = {up_cnt, 2'b00} - DE_W'(8);
  assign de     = ctr_r ? $signed(de_up) : $signed(-de_up);

  assign is_write = (act_r == isms_pkg::ACT_WRITE);
  assign is_trial = (act_r == isms_pkg::ACT_TRIAL);

  always_comb begin
    if (de[DE_W-1] || de == '0)  accept = 1'b1;
    else if (de == DE_W'(4))     accept = draw_r < thr_four;
    else                         accept = draw_r < thr_eight;
  end

  assign we = cmd.commit & (is_write | (is_trial & accept));
  assign wd = is_write ? wbit_r : ~ctr_r;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic                   spin_r, flip_r;
  logic signed [DE_W-1:0] de_r;

  assign out_valid_nxt = cmd.commit | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      spin_r <= is_write ? wbit_r : (is_trial ? (ctr_r ^ accept) : ctr_r);
      flip_r <= is_trial & accept;
      de_r   <= is_trial ? de : '0;
    end
  end

  assign sts.is_write = is_write;
  assign sts.out_free = ~out_valid_r | out_ready;

  assign out_valid         = out_valid_r;
  assign out_spin_out      = spin_r;
  assign out_flipped       = flip_r;
  assign out_energy_change = de_r;

endmodule

/* rtl/core/ising_metropolis_site_update.sv */
// ----------------------------------------------------------------------------
// ising_metropolis_site_update
// Single-spin-flip Metropolis update on a wrapped square lattice of spins.
//
//   port      dir  handshake             payload
//   in_if     in   valid/ready           action, row, column, spin_value,
//                                        random_draw
//   out_if    out  valid/ready           spin_out, flipped, energy_change
//   cfg_*     in   APB write/read        accept_threshold_four at 0x0,
//                                        accept_threshold_eight at 0x4
//
// One item in work at a time: a write steps through RD0 and FIN, a read or
// trial through RD0, RD1, RD2 and FIN, its result registered at the commit;
// a trial reads five sites in RD0, RD1 and RD2 over the two read ports.
// Reset idles the controller and loads the default thresholds; the lattice
// is unset until written.
// A held result stalls the commit step, and no next item is taken meanwhile.
// ----------------------------------------------------------------------------
module ising_metropolis_site_update #(
  parameter int unsigned LATTICE_SIDE = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  isms_in_if.sink                       in_if,
  isms_out_if.source                    out_if,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [isms_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [isms_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [isms_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  logic [isms_pkg::THR_W-1:0] thr_four_r, thr_eight_r;
  logic                       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_four_r  <= isms_pkg::THR_FOUR_RST;
      thr_eight_r <= isms_pkg::THR_EIGHT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == isms_pkg::REG_THR_FOUR)
        thr_four_r  <= cfg_pwdata[isms_pkg::THR_W-1:0];
      else
        thr_eight_r <= cfg_pwdata[isms_pkg::THR_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == isms_pkg::REG_THR_EIGHT)
                    ? isms_pkg::APB_DW'(thr_eight_r)
                    : isms_pkg::APB_DW'(thr_four_r);

  isms_pkg::isms_cmd_t cmd;
  isms_pkg::isms_sts_t sts;
  logic                in_ready;

  assign in_if.ready = in_ready;

  isms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  isms_dp #(
    .LATTICE_SIDE (LATTICE_SIDE)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_action         (in_if.action),
    .in_row            (in_if.row),
    .in_column         (in_if.column),
    .in_spin_value     (in_if.spin_value),
    .in_random_draw    (in_if.random_draw),
    .thr_four          (thr_four_r),
    .thr_eight         (thr_eight_r),
    .out_valid         (out_if.valid),
    .out_ready         (out_if.ready),
    .out_spin_out      (out_if.spin_out),
    .out_flipped       (out_if.flipped),
    .out_energy_change (out_if.energy_change)
  );

endmodule
